@@ design/dthr_pkg.sv @@
// ----------------------------------------------------------------------------
// dthr_pkg
// Shared constants, types and sizes of the device test handshake responder.
// ----------------------------------------------------------------------------
package dthr_pkg;

	// slot table
	localparam int SLOTS = 32;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

	// command queue between front and back
	localparam int QDEPTH = 2;

	// packet header and control codes
	localparam logic [7:0] HEAD_FIRST     = 8'hE4;
	localparam logic [7:0] HEAD_SECOND    = 8'hFB;
	localparam logic [7:0] CTRL_HANDSHAKE = 8'h01;
	localparam logic [7:0] CTRL_UPLINK1   = 8'hF1;
	localparam logic [7:0] CTRL_UPLINK2   = 8'hF3;

	// response frame bytes
	localparam logic [7:0] SYNC_FIRST  = 8'hC8;
	localparam logic [7:0] SYNC_SECOND = 8'hDF;
	localparam logic [7:0] ACK_CODE    = 8'h01;
	localparam logic [7:0] DL1_CODE    = 8'hF2;
	localparam logic [7:0] DL2_CODE    = 8'hF4;
	localparam logic [7:0] ACK_MARK    = 8'h01;
	localparam logic [7:0] ACK_TAIL_A  = 8'hB0;
	localparam logic [7:0] ACK_TAIL_B  = 8'hFB;
	localparam logic [7:0] SERIAL_OK   = 8'hFF;

	typedef enum logic [2:0] {
		ST_ACK      = 3'd0,
		ST_DL1      = 3'd1,
		ST_DL2      = 3'd2,
		ST_FULL     = 3'd3,
		ST_UNKNOWN  = 3'd4,
		ST_BAD_HEAD = 3'd5,
		ST_BAD_CTRL = 3'd6
	} status_t;

	// one classified packet, ready to be turned into items
	typedef struct packed {
		status_t            status;
		logic [63:0]        id;
		logic [7:0]         f11;
		logic [7:0]         f12;
		logic               report;
		logic               pass;
		logic signed [7:0]  up_rssi;
		logic signed [7:0]  down_rssi;
		logic signed [7:0]  up_snr;
		logic signed [7:0]  down_snr;
	} cmd_t;

endpackage

@@ design/dthr_in_if.sv @@
// ----------------------------------------------------------------------------
// dthr_in_if
// Packet channel: valid, ready and the received packet fields.
// ----------------------------------------------------------------------------
interface dthr_in_if;
	logic              valid;
	logic              ready;
	logic [7:0]        head_first;
	logic [7:0]        head_second;
	logic [7:0]        ctrl_code;
	logic [63:0]       device_id;
	logic [7:0]        byte_eleven;
	logic [7:0]        byte_twelve;
	logic [7:0]        byte_thirteen;
	logic signed [7:0] link_rssi;
	logic signed [7:0] link_snr;

	modport source (
		output valid, head_first, head_second, ctrl_code, device_id,
		       byte_eleven, byte_twelve, byte_thirteen, link_rssi, link_snr,
		input  ready
	);
	modport sink (
		input  valid, head_first, head_second, ctrl_code, device_id,
		       byte_eleven, byte_twelve, byte_thirteen, link_rssi, link_snr,
		output ready
	);
endinterface

@@ design/dthr_out_if.sv @@
// ----------------------------------------------------------------------------
// dthr_out_if
// Response channel: valid, ready and one response item.
// ----------------------------------------------------------------------------
interface dthr_out_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [7:0]        tx_byte;
	logic              tx_valid;
	logic              last;
	logic              report_valid;
	logic              serial_pass;
	logic signed [7:0] up_rssi;
	logic signed [7:0] down_rssi;
	logic signed [7:0] up_snr;
	logic signed [7:0] down_snr;

	modport source (
		output valid, status, tx_byte, tx_valid, last, report_valid, serial_pass,
		       up_rssi, down_rssi, up_snr, down_snr,
		input  ready
	);
	modport sink (
		input  valid, status, tx_byte, tx_valid, last, report_valid, serial_pass,
		       up_rssi, down_rssi, up_snr, down_snr,
		output ready
	);
endinterface

@@ design/dthr_ram.sv @@
// ----------------------------------------------------------------------------
// dthr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dthr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/dthr_front.sv @@
// ----------------------------------------------------------------------------
// dthr_front
// Accepts packets, checks the header and control code, walks the slot table for
// valid packets and updates it, then hands one command per packet to the back end.
// ----------------------------------------------------------------------------
module dthr_front
	import dthr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     tx_power,
	dthr_in_if.sink        pkt,
	output logic           push_valid,
	input  logic           push_ready,
	output cmd_t           push_cmd
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_PUSH
	} state_t;

	typedef enum logic [1:0] {
		OP_HANDSHAKE,
		OP_UPLINK1,
		OP_UPLINK2
	} op_t;

	state_t            state_q;
	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SLOTS-1:0]  slot_valid_q;
	cmd_t              cmd_q;
	logic [63:0]       id_q;
	logic [7:0]        b11_q;
	logic [7:0]        b12_q;
	logic [7:0]        b13_q;
	logic signed [7:0] rssi_q;
	logic signed [7:0] snr_q;

	logic [63:0]       rd_id;
	logic [23:0]       rd_data;
	logic              found;
	logic              id_we;
	logic              data_we;
	cmd_t              hit_cmd;

	function automatic cmd_t status_cmd(status_t st);
		cmd_t c;
		c = '0;
		c.status = st;
		return c;
	endfunction

	dthr_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (idx_q),
		.wdata (id_q),
		.raddr (idx_q),
		.rdata (rd_id)
	);

	// serial result, gateway rssi, gateway snr
	dthr_ram #(.WIDTH(24), .DEPTH(SLOTS)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (idx_q),
		.wdata ({b13_q, rssi_q, snr_q}),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_comb begin
		if (op_q == OP_HANDSHAKE) begin
			found = !slot_valid_q[idx_q];
		end else begin
			found = slot_valid_q[idx_q] && (rd_id == id_q);
		end
	end

	// command for a packet that found its slot
	always_comb begin
		hit_cmd    = '0;
		hit_cmd.id = id_q;
		unique case (op_q)
			OP_HANDSHAKE: begin
				hit_cmd.status = ST_ACK;
				hit_cmd.f11    = ACK_MARK;
				hit_cmd.f12    = tx_power;
			end
			OP_UPLINK1: begin
				hit_cmd.status = ST_DL1;
				hit_cmd.f11    = rssi_q;
				hit_cmd.f12    = snr_q;
			end
			OP_UPLINK2: begin
				hit_cmd.status    = ST_DL2;
				hit_cmd.report    = 1'b1;
				hit_cmd.pass      = (rd_data[23:16] == SERIAL_OK);
				hit_cmd.up_rssi   = rd_data[15:8];
				hit_cmd.up_snr    = rd_data[7:0];
				hit_cmd.down_rssi = b11_q;
				hit_cmd.down_snr  = b12_q;
			end
			default: begin
				hit_cmd.status = ST_BAD_CTRL;
			end
		endcase
	end

	assign id_we      = (state_q == S_CHECK) && found && (op_q == OP_HANDSHAKE);
	assign data_we    = (state_q == S_CHECK) && found && (op_q == OP_UPLINK1);
	assign pkt.ready  = (state_q == S_IDLE);
	assign push_valid = (state_q == S_PUSH);
	assign push_cmd   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_HANDSHAKE;
			idx_q        <= '0;
			slot_valid_q <= '0;
			cmd_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pkt.valid) begin
						id_q   <= pkt.device_id;
						b11_q  <= pkt.byte_eleven;
						b12_q  <= pkt.byte_twelve;
						b13_q  <= pkt.byte_thirteen;
						rssi_q <= pkt.link_rssi;
						snr_q  <= pkt.link_snr;
						idx_q  <= '0;
						if (pkt.head_first != HEAD_FIRST || pkt.head_second != HEAD_SECOND) begin
							cmd_q   <= status_cmd(ST_BAD_HEAD);
							state_q <= S_PUSH;
						end else if (pkt.ctrl_code == CTRL_HANDSHAKE) begin
							op_q    <= OP_HANDSHAKE;
							state_q <= S_READ;
						end else if (pkt.ctrl_code == CTRL_UPLINK1) begin
							op_q    <= OP_UPLINK1;
							state_q <= S_READ;
						end else if (pkt.ctrl_code == CTRL_UPLINK2) begin
							op_q    <= OP_UPLINK2;
							state_q <= S_READ;
						end else begin
							cmd_q   <= status_cmd(ST_BAD_CTRL);
							state_q <= S_PUSH;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (found) begin
						cmd_q   <= hit_cmd;
						state_q <= S_PUSH;
						if (op_q == OP_HANDSHAKE) begin
							slot_valid_q[idx_q] <= 1'b1;
						end else if (op_q == OP_UPLINK2) begin
							slot_valid_q[idx_q] <= 1'b0;
						end
					end else if (idx_q == LAST_SLOT) begin
						cmd_q   <= status_cmd((op_q == OP_HANDSHAKE) ? ST_FULL : ST_UNKNOWN);
						state_q <= S_PUSH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_PUSH: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ design/dthr_queue.sv @@
// ----------------------------------------------------------------------------
// dthr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dthr_queue
	import dthr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);
	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ design/dthr_back.sv @@
// ----------------------------------------------------------------------------
// dthr_back
// Turns each command into its response items, one frame byte per item, or a
// single status item for an error, through an output register.
// ----------------------------------------------------------------------------
module dthr_back
	import dthr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  cmd_t     cmd,
	dthr_out_if.source rsp
);
	localparam logic [3:0] ACK_LAST = 4'd15;
	localparam logic [3:0] DL_LAST  = 4'd13;

	typedef struct packed {
		status_t           status;
		logic [7:0]        tx_byte;
		logic              tx_valid;
		logic              last;
		logic              report_valid;
		logic              serial_pass;
		logic signed [7:0] up_rssi;
		logic signed [7:0] down_rssi;
		logic signed [7:0] up_snr;
		logic signed [7:0] down_snr;
	} item_t;

	logic [3:0] idx_q;
	logic       out_valid_q;
	item_t      out_q;
	item_t      item;
	logic       is_frame;
	logic       is_last;
	logic       load;

	function automatic logic [7:0] frame_byte(cmd_t c, logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:  b = SYNC_FIRST;
			4'd1:  b = SYNC_SECOND;
			4'd2:  b = (c.status == ST_ACK) ? ACK_CODE :
			           (c.status == ST_DL1) ? DL1_CODE : DL2_CODE;
			4'd3:  b = c.id[63:56];
			4'd4:  b = c.id[55:48];
			4'd5:  b = c.id[47:40];
			4'd6:  b = c.id[39:32];
			4'd7:  b = c.id[31:24];
			4'd8:  b = c.id[23:16];
			4'd9:  b = c.id[15:8];
			4'd10: b = c.id[7:0];
			4'd11: b = c.f11;
			4'd12: b = c.f12;
			4'd13: b = (c.status == ST_ACK) ? ACK_TAIL_A : 8'h00;
			4'd14: b = ACK_TAIL_B;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	assign is_frame = (cmd.status == ST_ACK) || (cmd.status == ST_DL1) ||
	                  (cmd.status == ST_DL2);
	assign is_last  = !is_frame ||
	                  (idx_q == ((cmd.status == ST_ACK) ? ACK_LAST : DL_LAST));
	assign load      = cmd_valid && (!out_valid_q || rsp.ready);
	assign cmd_ready = load && is_last;

	always_comb begin
		item          = '0;
		item.status   = cmd.status;
		item.last     = is_last;
		item.tx_valid = is_frame;
		if (is_frame) begin
			item.tx_byte = frame_byte(cmd, idx_q);
		end
		// report fields ride on the final item only
		if (cmd.report && is_last) begin
			item.report_valid = 1'b1;
			item.serial_pass  = cmd.pass;
			item.up_rssi      = cmd.up_rssi;
			item.down_rssi    = cmd.down_rssi;
			item.up_snr       = cmd.up_snr;
			item.down_snr     = cmd.down_snr;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 4'd0 : idx_q + 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.tx_byte      = out_q.tx_byte;
	assign rsp.tx_valid     = out_q.tx_valid;
	assign rsp.last         = out_q.last;
	assign rsp.report_valid = out_q.report_valid;
	assign rsp.serial_pass  = out_q.serial_pass;
	assign rsp.up_rssi      = out_q.up_rssi;
	assign rsp.down_rssi    = out_q.down_rssi;
	assign rsp.up_snr       = out_q.up_snr;
	assign rsp.down_snr     = out_q.down_snr;
endmodule

@@ design/device_test_handshake_responder.sv @@
// ----------------------------------------------------------------------------
// device_test_handshake_responder
// Checks received test packets, keeps a table of devices under test and
// answers with acknowledge and downlink frames, one byte per item.
// The front walks the table from slot 0 with one RAM read and one compare
// per slot up to the slot it reaches; header and control errors skip the walk.
// The back sends one item per cycle while the response sink is ready, 16 or 14
// per frame, and the front takes the next packet once its command is queued.
// Reset clears the slot valid bits, the command queue, the output register
// and tx_power; the slot RAMs keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module device_test_handshake_responder
	import dthr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	dthr_in_if.sink    pkt,
	dthr_out_if.source rsp
);
	logic [7:0] tx_power_q;
	logic       push_valid;
	logic       push_ready;
	cmd_t       push_cmd;
	logic       pop_valid;
	logic       pop_ready;
	cmd_t       pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_power_q <= '0;
		end else if (cfg_we) begin
			tx_power_q <= cfg_wdata;
		end
	end

	dthr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tx_power   (tx_power_q),
		.pkt        (pkt),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	dthr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dthr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.rsp       (rsp)
	);
endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the device test handshake responder. Received packets are
// driven through the packet channel; every response item is checked against
// a predictor that keeps its own slot table and transmit power byte. Both
// channels stall in random bursts. The run covers header and control errors,
// unknown ids, duplicate handshakes, a full table and whole test lifecycles
// under several transmit power settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import dthr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SHOWN_ERRORS = 40;

	typedef struct packed {
		logic [7:0]        head_first;
		logic [7:0]        head_second;
		logic [7:0]        ctrl;
		logic [63:0]       id;
		logic [7:0]        b11;
		logic [7:0]        b12;
		logic [7:0]        b13;
		logic signed [7:0] rssi;
		logic signed [7:0] snr;
	} packet_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        tx_byte;
		logic              tx_valid;
		logic              last;
		logic              report_valid;
		logic              serial_pass;
		logic signed [7:0] up_rssi;
		logic signed [7:0] down_rssi;
		logic signed [7:0] up_snr;
		logic signed [7:0] down_snr;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	dthr_in_if  pkt_if ();
	dthr_out_if rsp_if ();

	device_test_handshake_responder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pkt       (pkt_if),
		.rsp       (rsp_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// packets waiting to be sent and response items still owed
	packet_t pend[$];
	reply_t  reply_due[$];
	packet_t on_wire;
	bit      in_flight = 1'b0;
	int      pkts_queued = 0;
	int      pkts_taken = 0;
	int      items_seen = 0;
	int      errors = 0;
	int      cycles = 0;
	bit      quiet = 1'b0;
	int      send_hold = 0;
	int      recv_hold = 0;
	int      calm_left [2] = '{0, 0};

	// predictor state
	logic [7:0]        power_byte = 8'h00;
	bit                tbl_valid [SLOTS];
	logic [63:0]       tbl_id [SLOTS];
	logic [7:0]        tbl_serial [SLOTS];
	logic signed [7:0] tbl_up_rssi [SLOTS];
	logic signed [7:0] tbl_up_snr [SLOTS];
	logic signed [7:0] tbl_down_rssi [SLOTS];
	logic signed [7:0] tbl_down_snr [SLOTS];
	int                n_reports = 0;
	int                n_full = 0;
	int                n_unknown = 0;

	// what the stimulus side believes the table holds, to keep uplinks legal
	bit          plan_valid [SLOTS];
	logic [63:0] plan_id [SLOTS];
	bit          plan_up1 [SLOTS];

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_id[k] = '0;
			tbl_serial[k] = '0;
			tbl_up_rssi[k] = '0;
			tbl_up_snr[k] = '0;
			tbl_down_rssi[k] = '0;
			tbl_down_snr[k] = '0;
			plan_valid[k] = 1'b0;
			plan_id[k] = '0;
			plan_up1[k] = 1'b0;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("[%0t] mismatch at item %0d: %s", $time, items_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic int tbl_find(input logic [63:0] id);
		for (int k = 0; k < SLOTS; k++)
			if (tbl_valid[k] && tbl_id[k] == id)
				return k;
		return -1;
	endfunction

	function automatic int plan_find(input logic [63:0] id);
		for (int k = 0; k < SLOTS; k++)
			if (plan_valid[k] && plan_id[k] == id)
				return k;
		return -1;
	endfunction

	// expected response items of one accepted packet
	task automatic predict_reply(input packet_t p);
		logic [7:0] frame [16];
		status_t    st;
		reply_t     r;
		int         n;
		int         s;
		n = 0;
		s = -1;
		frame[0] = SYNC_FIRST;
		frame[1] = SYNC_SECOND;
		for (int k = 2; k < 16; k++)
			frame[k] = 8'h00;
		if (p.head_first != HEAD_FIRST || p.head_second != HEAD_SECOND) begin
			st = ST_BAD_HEAD;
		end else if (p.ctrl == CTRL_HANDSHAKE) begin
			for (int k = SLOTS - 1; k >= 0; k--)
				if (!tbl_valid[k])
					s = k;
			if (s < 0) begin
				st = ST_FULL;
				n_full++;
			end else begin
				tbl_valid[s] = 1'b1;
				tbl_id[s] = p.id;
				st = ST_ACK;
				n = 16;
				frame[2] = ACK_CODE;
				frame[11] = ACK_MARK;
				frame[12] = power_byte;
				frame[13] = ACK_TAIL_A;
				frame[14] = ACK_TAIL_B;
			end
		end else if (p.ctrl == CTRL_UPLINK1 || p.ctrl == CTRL_UPLINK2) begin
			s = tbl_find(p.id);
			if (s < 0) begin
				st = ST_UNKNOWN;
				n_unknown++;
			end else if (p.ctrl == CTRL_UPLINK1) begin
				tbl_serial[s] = p.b13;
				tbl_up_rssi[s] = p.rssi;
				tbl_up_snr[s] = p.snr;
				st = ST_DL1;
				n = 14;
				frame[2] = DL1_CODE;
				frame[11] = p.rssi;
				frame[12] = p.snr;
			end else begin
				tbl_down_rssi[s] = p.b11;
				tbl_down_snr[s] = p.b12;
				st = ST_DL2;
				n = 14;
				frame[2] = DL2_CODE;
			end
		end else begin
			st = ST_BAD_CTRL;
		end

		// id bytes go out most significant first
		for (int k = 0; k < 8; k++)
			frame[3 + k] = p.id[63 - 8 * k -: 8];

		if (n == 0) begin
			r = '0;
			r.status = st;
			r.last = 1'b1;
			reply_due.push_back(r);
		end
		for (int k = 0; k < n; k++) begin
			r = '0;
			r.status = st;
			r.tx_byte = frame[k];
			r.tx_valid = 1'b1;
			r.last = (k == n - 1);
			if (k == n - 1 && st == ST_DL2) begin
				r.report_valid = 1'b1;
				r.serial_pass = (tbl_serial[s] == SERIAL_OK);
				r.up_rssi = tbl_up_rssi[s];
				r.down_rssi = tbl_down_rssi[s];
				r.up_snr = tbl_up_snr[s];
				r.down_snr = tbl_down_snr[s];
				tbl_valid[s] = 1'b0;
				n_reports++;
			end
			reply_due.push_back(r);
		end
	endtask

	task automatic queue_packet(input packet_t p);
		int s;
		s = -1;
		pend.push_back(p);
		pkts_queued++;
		if (p.head_first == HEAD_FIRST && p.head_second == HEAD_SECOND) begin
			if (p.ctrl == CTRL_HANDSHAKE) begin
				for (int k = SLOTS - 1; k >= 0; k--)
					if (!plan_valid[k])
						s = k;
				if (s >= 0) begin
					plan_valid[s] = 1'b1;
					plan_id[s] = p.id;
					plan_up1[s] = 1'b0;
				end
			end else if (p.ctrl == CTRL_UPLINK1 || p.ctrl == CTRL_UPLINK2) begin
				s = plan_find(p.id);
				if (s >= 0 && p.ctrl == CTRL_UPLINK1)
					plan_up1[s] = 1'b1;
				else if (s >= 0)
					plan_valid[s] = 1'b0;
			end
		end
	endtask

	function automatic packet_t pk(input logic [7:0] h1, input logic [7:0] h2,
			input logic [7:0] ctrl, input logic [63:0] id, input logic [7:0] b11,
			input logic [7:0] b12, input logic [7:0] b13, input logic [7:0] rssi,
			input logic [7:0] snr);
		packet_t p;
		p.head_first = h1;
		p.head_second = h2;
		p.ctrl = ctrl;
		p.id = id;
		p.b11 = b11;
		p.b12 = b12;
		p.b13 = b13;
		p.rssi = rssi;
		p.snr = snr;
		return p;
	endfunction

	// mostly legal lifecycle traffic, with some noise and unknown ids
	task automatic plan_random(input int hs_weight);
		packet_t p;
		int      roll;
		int      live[$];
		int      ripe[$];
		p = pk(HEAD_FIRST, HEAD_SECOND, CTRL_HANDSHAKE, {$urandom, $urandom},
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		for (int k = 0; k < SLOTS; k++) begin
			if (plan_valid[k]) begin
				live.push_back(k);
				// uplink2 only where the matched slot has seen uplink1
				if (plan_find(plan_id[k]) == k && plan_up1[k])
					ripe.push_back(k);
			end
		end
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			do begin
				case ($urandom_range(0, 2))
					0: p.head_first = 8'($urandom);
					1: p.head_second = 8'($urandom);
					default: begin
						p.head_first = 8'($urandom);
						p.head_second = 8'($urandom);
					end
				endcase
			end while (p.head_first == HEAD_FIRST && p.head_second == HEAD_SECOND);
			p.ctrl = 8'($urandom);
		end else if (roll < 10) begin
			do p.ctrl = 8'($urandom);
			while (p.ctrl == CTRL_HANDSHAKE || p.ctrl == CTRL_UPLINK1 ||
				p.ctrl == CTRL_UPLINK2);
		end else if (roll < 14) begin
			p.ctrl = $urandom_range(0, 1) ? CTRL_UPLINK1 : CTRL_UPLINK2;
			while (plan_find(p.id) >= 0)
				p.id = {$urandom, $urandom};
		end else if (roll < 14 + hs_weight || live.size() == 0) begin
			if (live.size() > 0 && $urandom_range(0, 5) == 0)
				p.id = plan_id[live[$urandom_range(0, live.size() - 1)]];
		end else if (ripe.size() > 0 && $urandom_range(0, 1)) begin
			p.ctrl = CTRL_UPLINK2;
			p.id = plan_id[ripe[$urandom_range(0, ripe.size() - 1)]];
		end else begin
			p.ctrl = CTRL_UPLINK1;
			p.id = plan_id[live[$urandom_range(0, live.size() - 1)]];
			if ($urandom_range(0, 1))
				p.b13 = SERIAL_OK;
		end
		queue_packet(p);
	endtask

	// 0 or the length of a stall burst; calm stretches keep a side busy
	function automatic int pick_gap(input int side);
		if (quiet)
			return 0;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left[side] = $urandom_range(20, 80);
			return 0;
		end
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(1, 12);
		return 0;
	endfunction

	task automatic set_power(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic await_idle();
		while (pkts_taken != pkts_queued || reply_due.size() != 0)
			@(negedge clk);
	endtask

	// packet driver
	always @(negedge clk) begin
		if (arst_n && !in_flight) begin
			if (send_hold == 0 && pend.size() > 0)
				send_hold = pick_gap(0);
			if (send_hold > 0) begin
				send_hold--;
				pkt_if.valid <= 1'b0;
			end else if (pend.size() == 0) begin
				pkt_if.valid <= 1'b0;
			end else begin
				on_wire = pend.pop_front();
				in_flight = 1'b1;
				pkt_if.head_first <= on_wire.head_first;
				pkt_if.head_second <= on_wire.head_second;
				pkt_if.ctrl_code <= on_wire.ctrl;
				pkt_if.device_id <= on_wire.id;
				pkt_if.byte_eleven <= on_wire.b11;
				pkt_if.byte_twelve <= on_wire.b12;
				pkt_if.byte_thirteen <= on_wire.b13;
				pkt_if.link_rssi <= on_wire.rssi;
				pkt_if.link_snr <= on_wire.snr;
				pkt_if.valid <= 1'b1;
			end
		end
	end

	// response sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_hold == 0)
				recv_hold = pick_gap(1);
			if (recv_hold > 0) begin
				recv_hold--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// monitor: check response items, predict on packet acceptance
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				items_seen++;
				if (reply_due.size() == 0) begin
					report_mismatch("item arrived with nothing expected");
				end else begin
					want = reply_due.pop_front();
					check_field("status", 8'(rsp_if.status), 8'(want.status));
					check_field("tx_byte", rsp_if.tx_byte, want.tx_byte);
					check_field("tx_valid", 8'(rsp_if.tx_valid), 8'(want.tx_valid));
					check_field("last", 8'(rsp_if.last), 8'(want.last));
					check_field("report_valid", 8'(rsp_if.report_valid),
						8'(want.report_valid));
					check_field("serial_pass", 8'(rsp_if.serial_pass),
						8'(want.serial_pass));
					check_field("up_rssi", rsp_if.up_rssi, want.up_rssi);
					check_field("down_rssi", rsp_if.down_rssi, want.down_rssi);
					check_field("up_snr", rsp_if.up_snr, want.up_snr);
					check_field("down_snr", rsp_if.down_snr, want.down_snr);
				end
			end
			if (pkt_if.valid && pkt_if.ready && in_flight) begin
				predict_reply(on_wire);
				in_flight = 1'b0;
				pkts_taken++;
			end
			if (cfg_we)
				power_byte = cfg_wdata;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still owed", cycles,
				reply_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0] power_set [4];
		int         phase_len [4];
		power_set = '{8'hFF, 8'h00, 8'h00, 8'h80};
		phase_len = '{100, 100, 70, 30};
		power_set[2] = 8'($urandom);
		pkt_if.valid = 1'b0;
		pkt_if.head_first = '0;
		pkt_if.head_second = '0;
		pkt_if.ctrl_code = '0;
		pkt_if.device_id = '0;
		pkt_if.byte_eleven = '0;
		pkt_if.byte_twelve = '0;
		pkt_if.byte_thirteen = '0;
		pkt_if.link_rssi = '0;
		pkt_if.link_snr = '0;
		rsp_if.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_power(8'h5A);
		// header and control errors, unknown ids
		queue_packet(pk(8'h00, HEAD_SECOND, CTRL_HANDSHAKE, 64'h0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, 8'h00, CTRL_HANDSHAKE, 64'h0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00));
		queue_packet(pk(8'hFF, 8'hFF, CTRL_UPLINK1, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, 8'h00, 64'h0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, 8'hFF, '1, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
			8'h80));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, DL1_CODE, 64'h1, 8'h01, 8'h02, 8'h03,
			8'h04, 8'h05));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK1, 64'h0123456789ABCDEF,
			8'h10, 8'h20, 8'hFF, 8'hF0, 8'h0F));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, 64'h0123456789ABCDEF,
			8'h10, 8'h20, 8'h30, 8'h40, 8'h50));
		// duplicate id takes a new slot; uplinks go to the lowest copy
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_HANDSHAKE, 64'h0, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_HANDSHAKE, '1, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_HANDSHAKE, 64'h0, 8'h55, 8'hAA,
			8'h55, 8'hAA, 8'h55));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK1, 64'h0, 8'h00, 8'h00,
			SERIAL_OK, 8'h80, 8'h7F));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, 64'h0, 8'h80, 8'h7F,
			8'h00, 8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK1, 64'h0, 8'h00, 8'h00,
			8'h00, 8'h7F, 8'h80));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK1, '1, 8'hFF, 8'hFF, 8'hFE,
			8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, '1, 8'hFF, 8'h00, 8'hFF,
			8'hFF, 8'hFF));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, 64'h0, 8'h7F, 8'h80,
			8'h00, 8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, 64'h0, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_HANDSHAKE, 64'hA5A5A5A5A5A5A5A5,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK1, 64'hA5A5A5A5A5A5A5A5,
			8'h00, 8'h00, SERIAL_OK, 8'hFF, 8'hFF));
		queue_packet(pk(HEAD_FIRST, HEAD_SECOND, CTRL_UPLINK2, 64'hA5A5A5A5A5A5A5A5,
			8'h7F, 8'h80, 8'h00, 8'h00, 8'h00));
		await_idle();

		// phase 1 is handshake heavy so the table fills up; the last one runs without stalls
		for (int ph = 0; ph < 4; ph++) begin
			set_power(power_set[ph]);
			quiet = (ph == 3);
			for (int i = 0; i < phase_len[ph]; i++)
				plan_random(ph == 1 ? 70 : 25);
			await_idle();
		end

		repeat (100) @(negedge clk);
		if (reply_due.size() != 0)
			report_mismatch($sformatf("%0d items never arrived", reply_due.size()));
		$display("covered %0d packets and %0d response items: %0d finished tests,",
			pkts_taken, items_seen, n_reports);
		$display("%0d full-table refusals, %0d unknown ids, 5 transmit power settings",
			n_full, n_unknown);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
design/dthr_pkg.sv
design/dthr_in_if.sv
design/dthr_out_if.sv
design/dthr_ram.sv
design/dthr_front.sv
design/dthr_queue.sv
design/dthr_back.sv
design/device_test_handshake_responder.sv
tb/sv/tb_top.sv
